// ----- sv/assert_macros.svh -----
// Assertion macros used by the scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that holds at every clock edge outside reset.
`define GES_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next cycle.
`define GES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GES_ASSERT(lbl, clk, rst_n, prop, msg)
`define GES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/ges_pkg.sv -----
// Types and constants of the goodness epoch scheduler.
// No dependencies; used by ges_table and goodness_epoch_scheduler.
package ges_pkg;

	localparam logic [8:0] CNT_MAX  = 9'd511;
	localparam logic [9:0] GOOD_MAX = 10'd1023;

	typedef enum logic [1:0] {
		RS_FREE  = 2'd0,
		RS_READY = 2'd1,
		RS_WAIT  = 2'd2,
		RS_CUR   = 2'd3
	} run_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_RD_SLOT,
		ST_W_WR_SLOT,
		ST_W_RD_CUR,
		ST_W_EMIT,
		ST_R_RD_CUR,
		ST_R_WR_CUR,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_EPOCH,
		ST_EPOCH_END,
		ST_SW_RD_CUR,
		ST_SW_WR_CUR,
		ST_SW_RD_NXT,
		ST_SW_WR_NXT
	} fsm_t;

	typedef enum logic {
		CMD_RESCHED = 1'b0,
		CMD_WRITE   = 1'b1
	} cmd_t;

	// One process slot as stored in the table memory.
	typedef struct packed {
		logic [7:0] prio;
		logic [8:0] cnt;
		logic [9:0] good;
		run_state_t state;
	} entry_t;

	typedef struct packed {
		logic       cmd;
		logic [4:0] slot;
		logic [7:0] base_priority;
		logic [1:0] slot_state;
		logic [8:0] ticks_left;
		logic       current_runnable;
	} in_t;

	typedef struct packed {
		logic [4:0] next_slot;
		logic       switched;
		logic [8:0] quantum;
		logic       epoch_started;
	} out_t;

endpackage

// ----- sv/ges_table.sv -----
// Process table memory: one write port, one registered read port.
// Uses ges_pkg; per-entry valid bits make unwritten entries read as reset values.
module ges_table #(
	parameter int NUM_SLOTS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
	output ges_pkg::entry_t              rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
	input  ges_pkg::entry_t              wr_data
);

	localparam int IW = $clog2(NUM_SLOTS);

	ges_pkg::entry_t        mem [NUM_SLOTS];
	ges_pkg::entry_t        rdata_q;
	logic [IW-1:0]          raddr_q;
	logic                   hit_q;
	logic [NUM_SLOTS-1:0]   valid_q;
	ges_pkg::entry_t        dflt;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (rd_en) begin
				hit_q <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Slot zero starts out as the running idle process, all others as free.
	always_comb begin
		dflt       = '0;
		dflt.state = (raddr_q == '0) ? ges_pkg::RS_CUR : ges_pkg::RS_FREE;
	end

	assign rd_data = hit_q ? rdata_q : dflt;

endmodule

// ----- sv/goodness_epoch_scheduler.sv -----
// Top level of the goodness epoch scheduler: command sequencer and datapath.
// Uses ges_pkg, ges_table and assert_macros.svh.
//
// Usage: present an item on "item" and raise start; the beat is taken at the
// rising edge where start is high and busy is low. Every item yields exactly one
// result beat, shown on "result" for a single cycle with done high. The receiver
// cannot stall, so capture the result in the cycle done is high. busy drops in
// that same cycle, so the next item may be started right away. All process state
// lives in one table memory with one read and one write port, and every item is
// a sequence of reads and write-backs on it. A slot write reads and rewrites the
// slot (unless it is outside the table), then reads the running slot. A
// reschedule charges the running process, scans the table, and keeps the running
// process or switches; a new epoch first recomputes every slot. The scan and the
// epoch pass each stream the table through the read port once, one slot a cycle.
// No clearing pass is needed after reset.
`include "assert_macros.svh"
module goodness_epoch_scheduler #(
	parameter int NUM_SLOTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ges_pkg::in_t  item,
	output logic          done,
	output ges_pkg::out_t result
);

	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	ges_pkg::fsm_t   state_q, state_d;

	// Control registers.
	logic [IW-1:0]   running_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   idx_s1;
	logic            pipe_v_s1;
	logic            done_q;

	// Payload registers.
	ges_pkg::in_t    item_q;
	ges_pkg::out_t   result_q;
	logic [8:0]      cnt_cur_q;
	logic [9:0]      good_cur_q;
	logic [9:0]      maxg_q;
	logic [IW-1:0]   best_q;
	logic [7:0]      best_prio_q;
	logic [IW-1:0]   nxt_q;
	logic            epoch_q;
	logic [8:0]      cnt0_q;

	// Table port signals.
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	ges_pkg::entry_t rd_data;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	ges_pkg::entry_t wr_data;

	// Datapath signals.
	logic            accept;
	logic            in_range;
	logic [IW-1:0]   slot_idx;
	logic            run_eff;
	ges_pkg::run_state_t wr_state;
	ges_pkg::entry_t cur_upd;
	ges_pkg::entry_t ep_upd;
	logic [9:0]      pri_base;
	logic [10:0]     cur_gsum;
	logic [9:0]      ep_csum;
	logic [8:0]      ep_cnt;
	logic [10:0]     ep_gsum;
	logic            scan_upd;
	logic            epoch_cond;
	logic            keep_cur;
	logic            emit_en;
	ges_pkg::out_t   emit_val;
	logic            run_we;

	ges_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign busy   = (state_q != ges_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// A slot beyond the table is never written; the range check uses the live item.
	assign in_range = (32'(item.slot) < NUM_SLOTS);
	assign slot_idx = IW'(item_q.slot);

	// The idle process always counts as runnable.
	assign run_eff = item_q.current_runnable || (running_q == '0);

	// A written state code of three is stored as waiting.
	assign wr_state = (item_q.slot_state == 2'(ges_pkg::RS_CUR)) ? ges_pkg::RS_WAIT
	                  : ges_pkg::run_state_t'(item_q.slot_state);

	// Charge the running process: recover its base priority from goodness minus
	// counter, then rebuild both from the remaining ticks.
	always_comb begin
		pri_base = (rd_data.good > 10'(rd_data.cnt)) ? (rd_data.good - 10'(rd_data.cnt)) : '0;
		cur_gsum = 11'(pri_base) + 11'(item_q.ticks_left);
		cur_upd  = rd_data;
		if ((running_q == '0) || (item_q.ticks_left == '0)) begin
			cur_upd.cnt  = '0;
			cur_upd.good = '0;
		end else begin
			cur_upd.cnt  = item_q.ticks_left;
			cur_upd.good = (cur_gsum > 11'(ges_pkg::GOOD_MAX)) ? ges_pkg::GOOD_MAX
			               : cur_gsum[9:0];
		end
	end

	// New epoch for one slot: occupied slots get priority plus half their counter.
	always_comb begin
		ep_csum = 10'(rd_data.prio) + 10'(rd_data.cnt[8:1]);
		if (rd_data.state != ges_pkg::RS_FREE) begin
			ep_cnt = (ep_csum > 10'(ges_pkg::CNT_MAX)) ? ges_pkg::CNT_MAX : ep_csum[8:0];
		end else begin
			ep_cnt = rd_data.cnt;
		end
		ep_gsum     = 11'(rd_data.prio) + 11'(ep_cnt);
		ep_upd      = rd_data;
		ep_upd.cnt  = ep_cnt;
		ep_upd.good = (ep_gsum > 11'(ges_pkg::GOOD_MAX)) ? ges_pkg::GOOD_MAX : ep_gsum[9:0];
	end

	// Running maximum of the scan; ties go to the higher priority, then the lower
	// slot, which is the one already held since slots arrive in ascending order.
	assign scan_upd = (rd_data.state == ges_pkg::RS_READY) &&
	                  ((rd_data.good > maxg_q) ||
	                   ((rd_data.good == maxg_q) && (maxg_q != '0) &&
	                    (rd_data.prio > best_prio_q)));

	assign epoch_cond = (cnt_cur_q == '0) && (maxg_q == '0);
	assign keep_cur   = run_eff && (good_cur_q != '0) && (good_cur_q >= maxg_q);

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = running_q;
		wr_en    = 1'b0;
		wr_addr  = running_q;
		wr_data  = rd_data;
		emit_en  = 1'b0;
		emit_val = '0;
		run_we   = 1'b0;
		case (state_q)
			ges_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.cmd == ges_pkg::CMD_WRITE) begin
						state_d = in_range ? ges_pkg::ST_W_RD_SLOT : ges_pkg::ST_W_RD_CUR;
					end else begin
						state_d = ges_pkg::ST_R_RD_CUR;
					end
				end
			end
			ges_pkg::ST_W_RD_SLOT: begin
				rd_en   = 1'b1;
				rd_addr = slot_idx;
				state_d = ges_pkg::ST_W_WR_SLOT;
			end
			ges_pkg::ST_W_WR_SLOT: begin
				wr_en        = 1'b1;
				wr_addr      = slot_idx;
				wr_data.prio = item_q.base_priority;
				// Slot zero and the running slot keep their state.
				if ((slot_idx != '0) && (slot_idx != running_q)) begin
					wr_data.state = wr_state;
				end
				state_d = ges_pkg::ST_W_RD_CUR;
			end
			ges_pkg::ST_W_RD_CUR: begin
				rd_en   = 1'b1;
				state_d = ges_pkg::ST_W_EMIT;
			end
			ges_pkg::ST_W_EMIT: begin
				emit_en            = 1'b1;
				emit_val.next_slot = 5'(running_q);
				emit_val.quantum   = rd_data.cnt;
				state_d            = ges_pkg::ST_IDLE;
			end
			ges_pkg::ST_R_RD_CUR: begin
				rd_en   = 1'b1;
				state_d = ges_pkg::ST_R_WR_CUR;
			end
			ges_pkg::ST_R_WR_CUR: begin
				wr_en   = 1'b1;
				wr_data = cur_upd;
				state_d = ges_pkg::ST_SCAN;
			end
			ges_pkg::ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				if (idx_q == LAST_IDX) begin
					state_d = ges_pkg::ST_SCAN_END;
				end
			end
			ges_pkg::ST_SCAN_END: begin
				state_d = ges_pkg::ST_DECIDE;
			end
			ges_pkg::ST_DECIDE: begin
				if (epoch_cond) begin
					state_d = ges_pkg::ST_EPOCH;
				end else if (keep_cur) begin
					emit_en            = 1'b1;
					emit_val.next_slot = 5'(running_q);
					emit_val.quantum   = cnt_cur_q;
					state_d            = ges_pkg::ST_IDLE;
				end else begin
					state_d = ges_pkg::ST_SW_RD_CUR;
				end
			end
			ges_pkg::ST_EPOCH: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				wr_en   = pipe_v_s1;
				wr_addr = idx_s1;
				wr_data = ep_upd;
				if (idx_q == LAST_IDX) begin
					state_d = ges_pkg::ST_EPOCH_END;
				end
			end
			ges_pkg::ST_EPOCH_END: begin
				wr_en   = pipe_v_s1;
				wr_addr = idx_s1;
				wr_data = ep_upd;
				if (running_q == '0) begin
					// The idle process stays on through a new epoch.
					emit_en                = 1'b1;
					emit_val.quantum       = cnt0_q;
					emit_val.epoch_started = 1'b1;
					state_d                = ges_pkg::ST_IDLE;
				end else begin
					state_d = ges_pkg::ST_SW_RD_CUR;
				end
			end
			ges_pkg::ST_SW_RD_CUR: begin
				rd_en   = 1'b1;
				state_d = ges_pkg::ST_SW_WR_CUR;
			end
			ges_pkg::ST_SW_WR_CUR: begin
				wr_en         = 1'b1;
				wr_data.state = run_eff ? ges_pkg::RS_READY : ges_pkg::RS_WAIT;
				state_d       = ges_pkg::ST_SW_RD_NXT;
			end
			ges_pkg::ST_SW_RD_NXT: begin
				rd_en   = 1'b1;
				rd_addr = nxt_q;
				state_d = ges_pkg::ST_SW_WR_NXT;
			end
			ges_pkg::ST_SW_WR_NXT: begin
				wr_en                  = 1'b1;
				wr_addr                = nxt_q;
				wr_data.state          = ges_pkg::RS_CUR;
				run_we                 = 1'b1;
				emit_en                = 1'b1;
				emit_val.next_slot     = 5'(nxt_q);
				emit_val.switched      = (nxt_q != running_q);
				emit_val.quantum       = rd_data.cnt;
				emit_val.epoch_started = epoch_q;
				state_d                = ges_pkg::ST_IDLE;
			end
			default: begin
				state_d = ges_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ges_pkg::ST_IDLE;
			running_q <= '0;
			idx_q     <= '0;
			idx_s1    <= '0;
			pipe_v_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= emit_en;
			pipe_v_s1 <= (state_q == ges_pkg::ST_SCAN) || (state_q == ges_pkg::ST_EPOCH);
			idx_s1    <= idx_q;
			if (run_we) begin
				running_q <= nxt_q;
			end
			if ((state_q == ges_pkg::ST_R_WR_CUR) || (state_q == ges_pkg::ST_DECIDE)) begin
				idx_q <= '0;
			end else if ((state_q == ges_pkg::ST_SCAN) || (state_q == ges_pkg::ST_EPOCH)) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (emit_en) begin
			result_q <= emit_val;
		end
		if (state_q == ges_pkg::ST_R_WR_CUR) begin
			cnt_cur_q   <= cur_upd.cnt;
			good_cur_q  <= cur_upd.good;
			maxg_q      <= '0;
			best_q      <= '0;
			best_prio_q <= '0;
		end
		if (pipe_v_s1 && ((state_q == ges_pkg::ST_SCAN) || (state_q == ges_pkg::ST_SCAN_END))
		    && scan_upd) begin
			maxg_q      <= rd_data.good;
			best_q      <= idx_s1;
			best_prio_q <= rd_data.prio;
		end
		if (state_q == ges_pkg::ST_DECIDE) begin
			epoch_q <= epoch_cond;
			nxt_q   <= epoch_cond ? '0 : best_q;
		end
		if (pipe_v_s1 && ((state_q == ges_pkg::ST_EPOCH) || (state_q == ges_pkg::ST_EPOCH_END))
		    && (idx_s1 == '0)) begin
			cnt0_q <= ep_upd.cnt;
		end
	end

	`GES_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`GES_ASSERT(a_done_idle, clk, arst_n, !done || !busy, "result shown while busy")
	`GES_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted beat left block idle")
	`GES_ASSERT(a_run_range, clk, arst_n, 32'(running_q) < NUM_SLOTS, "running slot beyond table")
	`GES_ASSERT(a_epoch_idle, clk, arst_n, !(done && result.epoch_started && !result.switched) || (result.next_slot == '0), "epoch without switch must keep idle slot")

endmodule

// ----- tb/goodness_epoch_scheduler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of goodness_epoch_scheduler: slot writes and reschedule beats,
// each checked against a behavioral scheduler kept inside a small scoreboard class.
// Depends on ges_pkg and the scheduler RTL; needs no files or arguments.
module goodness_epoch_scheduler_tb;

	localparam int NUM_SLOTS    = 32;
	localparam int RANDOM_ITEMS = 1930;
	localparam int PHASE_LEN    = 150;
	// The slowest beat is a switching reschedule that also opens an epoch, which
	// streams the table twice, and the sender may idle between beats. The limit on
	// cycles with neither an accepted beat nor a result beat lies far above that.
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 20;

	// Scoreboard: holds its own copy of the process table, works out the grant that
	// every accepted beat must produce, and compares the result beats in order.
	class grant_tracker;
		logic [7:0]          prio_tab [NUM_SLOTS];
		logic [8:0]          cnt_tab  [NUM_SLOTS];
		logic [9:0]          good_tab [NUM_SLOTS];
		ges_pkg::run_state_t st_tab   [NUM_SLOTS];
		logic [4:0]          running;
		ges_pkg::out_t       pending_grants [$];
		int                  errors;
		int                  epochs;
		int                  switches;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				prio_tab[i] = '0;
				cnt_tab[i]  = '0;
				good_tab[i] = '0;
				st_tab[i]   = ges_pkg::RS_FREE;
			end
			st_tab[0] = ges_pkg::RS_CUR;
			running   = '0;
			errors    = 0;
			epochs    = 0;
			switches  = 0;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned m);
			return (v > m) ? m : v;
		endfunction

		// Applies one beat to the table and returns the grant it must report.
		function ges_pkg::out_t schedule(ges_pkg::in_t it);
			ges_pkg::out_t r;
			int unsigned   cur;
			int unsigned   g;
			int unsigned   c;
			int unsigned   p;
			int unsigned   maxg;
			int unsigned   best;
			int unsigned   nxt;
			int unsigned   i;
			logic          runnable;

			cur = 32'(running);
			r   = '0;
			if (it.cmd == ges_pkg::CMD_WRITE) begin
				// Priority always lands; the state is left alone for the idle slot and
				// for the running slot, and code three is folded into waiting.
				if (it.slot < NUM_SLOTS) begin
					prio_tab[it.slot] = it.base_priority;
					if (it.slot != 0 && it.slot != cur)
						st_tab[it.slot] = (it.slot_state == ges_pkg::RS_CUR) ?
							ges_pkg::RS_WAIT : ges_pkg::run_state_t'(it.slot_state);
				end
				r.next_slot = 5'(cur);
				r.quantum   = cnt_tab[cur];
				return r;
			end

			runnable = (cur == 0) ? 1'b1 : it.current_runnable;

			// Charge the running slot: its base priority is what its goodness holds
			// above its counter.
			g = 32'(good_tab[cur]);
			c = 32'(cnt_tab[cur]);
			p = (g > c) ? g - c : 0;
			if (cur == 0 || it.ticks_left == 0) begin
				cnt_tab[cur]  = '0;
				good_tab[cur] = '0;
			end else begin
				cnt_tab[cur]  = it.ticks_left;
				good_tab[cur] = 10'(clip(p + 32'(it.ticks_left), 32'(ges_pkg::GOOD_MAX)));
			end

			// Best ready slot: highest goodness, then higher priority, then lower slot.
			best = 0;
			maxg = 0;
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (st_tab[i] == ges_pkg::RS_READY && i != cur) begin
					g = 32'(good_tab[i]);
					if (g > maxg || (g == maxg && maxg > 0 && prio_tab[i] > prio_tab[best])) begin
						maxg = g;
						best = i;
					end
				end
			end

			nxt = best;
			if (cnt_tab[cur] == 0 && maxg == 0) begin
				// Everyone is exhausted: recompute counters and goodness for a new epoch.
				epochs++;
				r.epoch_started = 1'b1;
				for (i = 0; i < NUM_SLOTS; i++) begin
					if (st_tab[i] != ges_pkg::RS_FREE)
						cnt_tab[i] = 9'(clip(32'(prio_tab[i]) + 32'(cnt_tab[i] >> 1),
							32'(ges_pkg::CNT_MAX)));
					good_tab[i] = 10'(clip(32'(prio_tab[i]) + 32'(cnt_tab[i]),
						32'(ges_pkg::GOOD_MAX)));
				end
				if (cur == 0) begin
					r.quantum = cnt_tab[0];
					return r;
				end
				nxt = 0;
			end else if (runnable && good_tab[cur] > 0 && good_tab[cur] >= maxg) begin
				r.next_slot = 5'(cur);
				r.quantum   = cnt_tab[cur];
				return r;
			end

			st_tab[cur] = runnable ? ges_pkg::RS_READY : ges_pkg::RS_WAIT;
			st_tab[nxt] = ges_pkg::RS_CUR;
			running     = 5'(nxt);
			r.next_slot = 5'(nxt);
			r.switched  = (nxt != cur);
			r.quantum   = cnt_tab[nxt];
			if (nxt != cur)
				switches++;
			return r;
		endfunction

		function void note_item(ges_pkg::in_t it);
			pending_grants.push_back(schedule(it));
		endfunction

		function void check_grant(ges_pkg::out_t got);
			ges_pkg::out_t exp;

			if (pending_grants.size() == 0) begin
				$error("result beat with no item outstanding: %p", got);
				errors++;
				return;
			end
			exp = pending_grants.pop_front();
			if (got.next_slot !== exp.next_slot) begin
				$error("next_slot: expected %0d, actual %0d", exp.next_slot, got.next_slot);
				errors++;
			end
			if (got.switched !== exp.switched) begin
				$error("switched: expected %0d, actual %0d", exp.switched, got.switched);
				errors++;
			end
			if (got.quantum !== exp.quantum) begin
				$error("quantum: expected %0d, actual %0d", exp.quantum, got.quantum);
				errors++;
			end
			if (got.epoch_started !== exp.epoch_started) begin
				$error("epoch_started: expected %0d, actual %0d", exp.epoch_started,
					got.epoch_started);
				errors++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          start;
	logic          busy;
	ges_pkg::in_t  item;
	logic          done;
	ges_pkg::out_t result;

	grant_tracker sched = new();
	int           n_writes = 0;
	int           n_resched = 0;
	int           quiet_cycles = 0;

	goodness_epoch_scheduler #(
		.NUM_SLOTS(NUM_SLOTS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	always #5 clk = ~clk;

	// Result beats cannot be held off, so every cycle with done high is checked.
	// Outputs are read in the active region right after the edge, i.e. the values
	// that the edge itself samples.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sched.check_grant(result);
	end

	// Watchdog: counts cycles in which neither an input nor a result beat moves.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Presents one beat and returns at the edge that takes it. Called at a rising
	// edge; start is left high so that a following beat can go out back to back.
	task automatic send(ges_pkg::in_t it);
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sched.note_item(it);
		if (it.cmd == ges_pkg::CMD_WRITE)
			n_writes++;
		else
			n_resched++;
	endtask

	// Fields that a beat does not use are filled with noise, so they toggle too.
	function automatic ges_pkg::in_t noise_item();
		logic [31:0]  raw;
		ges_pkg::in_t it;

		raw = $urandom;
		it  = raw[$bits(ges_pkg::in_t)-1:0];
		return it;
	endfunction

	function automatic ges_pkg::in_t write_item(logic [4:0] slot, logic [7:0] prio,
		logic [1:0] st);
		ges_pkg::in_t it;

		it               = noise_item();
		it.cmd           = ges_pkg::CMD_WRITE;
		it.slot          = slot;
		it.base_priority = prio;
		it.slot_state    = st;
		return it;
	endfunction

	function automatic ges_pkg::in_t resched_item(logic [8:0] ticks, logic runnable);
		ges_pkg::in_t it;

		it                  = noise_item();
		it.cmd              = ges_pkg::CMD_RESCHED;
		it.ticks_left       = ticks;
		it.current_runnable = runnable;
		return it;
	endfunction

	// Random beat. Most slot writes target the active pool so that the ready set
	// stays populated, and reschedules usually report a plausible count of ticks
	// left, drawn up to the quantum the running process was granted.
	function automatic ges_pkg::in_t random_item(int pool, int prio_mode);
		int          r;
		int unsigned q;
		logic [4:0]  slot;
		logic [7:0]  prio;
		logic [1:0]  st;
		logic [8:0]  ticks;

		r = $urandom_range(99);
		if (r < 28) begin
			r = $urandom_range(99);
			if (r < 5)
				slot = '0;
			else if (r < 10)
				slot = sched.running;
			else if (r < 15)
				slot = 5'($urandom_range(NUM_SLOTS - 1));
			else
				slot = 5'($urandom_range(pool, 1));
			case (prio_mode)
				0: prio = 8'($urandom_range(15));
				1: prio = 8'($urandom_range(255));
				default: begin
					r = $urandom_range(5);
					prio = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd128 :
						(r == 3) ? 8'd127 : 8'($urandom_range(255));
				end
			endcase
			r = $urandom_range(99);
			st = (r < 55) ? ges_pkg::RS_READY : (r < 75) ? ges_pkg::RS_WAIT :
				(r < 87) ? ges_pkg::RS_FREE : ges_pkg::RS_CUR;
			return write_item(slot, prio, st);
		end

		q = 32'(sched.cnt_tab[sched.running]);
		r = $urandom_range(99);
		if (r < 25)
			ticks = '0;
		else if (r < 33)
			ticks = ges_pkg::CNT_MAX;
		else if (r < 48)
			ticks = 9'($urandom_range(511));
		else
			ticks = 9'($urandom_range(q));
		return resched_item(ticks, $urandom_range(99) < 80);
	endfunction

	initial begin
		int k;
		int pool;
		int prio_mode;
		int gap_pct;

		start  <= 1'b0;
		item   <= '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Right after reset only the idle slot exists, so the first
		// reschedule opens an epoch and keeps the idle slot running.
		send(resched_item(9'd0, 1'b0));
		// State writes to the idle slot are dropped, its priority is kept.
		send(write_item(5'd0, 8'd255, ges_pkg::RS_READY));
		send(resched_item(9'd511, 1'b1));
		send(write_item(5'd31, 8'd255, ges_pkg::RS_READY));
		send(write_item(5'd1, 8'd0, ges_pkg::RS_READY));
		// State code three must be stored as waiting.
		send(write_item(5'd2, 8'd10, ges_pkg::RS_CUR));
		send(write_item(5'd3, 8'd10, ges_pkg::RS_READY));
		send(write_item(5'd4, 8'd10, ges_pkg::RS_READY));
		// Ready slots still have zero goodness, so this opens an epoch; the idle
		// slot ignores the blocked flag and keeps running.
		send(resched_item(9'd0, 1'b0));
		// The idle slot is zeroed and the highest goodness wins.
		send(resched_item(9'd0, 1'b1));
		send(resched_item(9'd511, 1'b1));
		// Writing the running slot changes its priority only.
		send(write_item(5'd31, 8'd0, ges_pkg::RS_FREE));
		// Slots 3 and 4 tie on goodness; slot 4 gets the higher priority and wins.
		send(write_item(5'd4, 8'd11, ges_pkg::RS_READY));
		send(resched_item(9'd0, 1'b0));
		send(resched_item(9'd5, 1'b1));
		send(resched_item(9'd0, 1'b0));
		send(write_item(5'd0, 8'd0, ges_pkg::RS_WAIT));
		send(write_item(5'd2, 8'd255, ges_pkg::RS_READY));
		send(resched_item(9'd1, 1'b1));
		// Run everyone dry so that an epoch starts with a real process running and
		// the block falls back to the idle slot.
		repeat (6) send(resched_item(9'd0, 1'b1));

		// Random part in phases: each phase picks a pool of active slots, a style of
		// priorities and an amount of sender idling. The tail runs with no idling.
		pool      = 4;
		prio_mode = 0;
		gap_pct   = 0;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % PHASE_LEN == 0) begin
				case ($urandom_range(4))
					0: pool = 2;
					1: pool = 4;
					2: pool = 8;
					3: pool = 16;
					default: pool = NUM_SLOTS - 1;
				endcase
				prio_mode = $urandom_range(2);
				case ($urandom_range(2))
					0: gap_pct = 0;
					1: gap_pct = 20;
					default: gap_pct = 50;
				endcase
				if (k >= RANDOM_ITEMS - 2 * PHASE_LEN)
					gap_pct = 0;
			end
			if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(9, 1)) @(posedge clk);
			end
			send(random_item(pool, prio_mode));
		end
		start <= 1'b0;

		// Drain: wait for every outstanding grant, then watch for stray beats.
		while (sched.pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d slot writes and %0d reschedules,", n_writes, n_resched);
		$display("with %0d process switches and %0d new epochs.", sched.switches,
			sched.epochs);
		if (sched.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
